// ===== design/lpmt_pkg.sv =====
// Shared types and constants for the LRU paged memory translator.
package lpmt_pkg;

    localparam int PAGE_BYTES  = 32;
    localparam int OFFSET_W    = 5;
    localparam int VADDR_W     = 13;
    localparam int RAW_PAGE_W  = VADDR_W - OFFSET_W;
    localparam int DATA_W      = 8;
    localparam int FRAME_OUT_W = 6;
    localparam int FAULT_W     = 32;

    typedef struct packed {
        logic                mode;
        logic [VADDR_W-1:0]  virtual_address;
        logic [DATA_W-1:0]   write_data;
    } lpmt_in_t;

    typedef struct packed {
        logic [DATA_W-1:0]      read_data;
        logic                   page_fault;
        logic [FRAME_OUT_W-1:0] frame_used;
        logic [FAULT_W-1:0]     fault_total;
    } lpmt_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_DECIDE,
        ST_PROMOTE,
        ST_ACCESS,
        ST_COPY,
        ST_FINISH
    } lpmt_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic reduce_step;
        logic scan_step;
        logic decide;
        logic promote_step;
        logic access;
        logic copy_step;
        logic finish;
    } lpmt_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic page_in_range;
        logic pass_done;
        logic is_hit;
        logic copy_done;
        logic out_free;
    } lpmt_status_t;

endpackage

// ===== design/lpmt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/lpmt_datapath.sv =====
// Datapath: request registers, frame table, frame and backing stores, result register.
module lpmt_datapath #(
    parameter int FRAME_COUNT   = 64,
    parameter int VIRTUAL_PAGES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpmt_pkg::lpmt_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lpmt_pkg::lpmt_out_t   m_data,
    input  lpmt_pkg::lpmt_cmd_t   cmd,
    output lpmt_pkg::lpmt_status_t status
);
    import lpmt_pkg::*;

    localparam int MAX_PAGES  = 2 ** RAW_PAGE_W;
    localparam int EFF_PAGES  = (VIRTUAL_PAGES < MAX_PAGES) ? VIRTUAL_PAGES : MAX_PAGES;
    localparam int PGW        = $clog2(EFF_PAGES);
    localparam int FW         = $clog2(FRAME_COUNT);
    localparam int RW         = FW;
    localparam int CW         = $clog2(FRAME_COUNT + 1);
    localparam int BACK_DEPTH = EFF_PAGES * PAGE_BYTES;
    localparam int BACK_AW    = PGW + OFFSET_W;
    localparam int FRAME_AW   = FW + OFFSET_W;
    localparam int TBL_W      = PGW + RW;

    logic                  mode_reg;
    logic [RAW_PAGE_W-1:0] page_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [BACK_AW-1:0]    clr_reg;
    logic [CW-1:0]         idx_reg;
    logic                  pend_reg;
    logic [FW-1:0]         pend_idx_reg;
    logic                  hit_reg;
    logic [FW-1:0]         hit_frame_reg;
    logic [RW-1:0]         hit_rank_reg;
    logic [FW-1:0]         lru_frame_reg;
    logic [FW-1:0]         frame_reg;
    logic [CW-1:0]         old_rank_reg;
    logic [CW-1:0]         fill_reg;
    logic [FAULT_W-1:0]    fault_total_reg;
    logic [5:0]            copy_reg;
    logic [DATA_W-1:0]     rdata_reg;
    logic                  m_valid_reg;
    lpmt_out_t             out_reg;

    logic [TBL_W-1:0]      tbl_rdata;
    logic [TBL_W-1:0]      tbl_wdata;
    logic [PGW-1:0]        tbl_owner;
    logic [RW-1:0]         tbl_rank;
    logic [PGW-1:0]        page_cut;
    logic [DATA_W-1:0]     back_rdata;
    logic [DATA_W-1:0]     frame_rdata;
    logic [5:0]            copy_prev;
    logic                  in_range;
    logic                  out_free;
    logic                  back_we;
    logic [BACK_AW-1:0]    back_waddr;
    logic [DATA_W-1:0]     back_wdata;
    logic                  frame_we;
    logic [FRAME_AW-1:0]   frame_waddr;
    logic [DATA_W-1:0]     frame_wdata;

    assign tbl_owner = tbl_rdata[TBL_W-1:RW];
    assign tbl_rank  = tbl_rdata[RW-1:0];
    assign page_cut  = PGW'(page_reg);
    assign copy_prev = copy_reg - 6'd1;
    assign in_range  = {1'b0, page_reg} < (RAW_PAGE_W + 1)'(EFF_PAGES);
    assign out_free  = !m_valid_reg || m_ready;

    assign status.clear_last    = (clr_reg == BACK_AW'(BACK_DEPTH - 1));
    assign status.page_in_range = in_range;
    assign status.pass_done     = (idx_reg == fill_reg) && !pend_reg;
    assign status.is_hit        = hit_reg;
    assign status.copy_done     = (copy_reg == 6'(PAGE_BYTES));
    assign status.out_free      = out_free;

    // Promotion rewrite of one table entry
    always_comb begin
        if (pend_idx_reg == frame_reg) begin
            tbl_wdata = {page_cut, RW'(0)};
        end else if (CW'(tbl_rank) < old_rank_reg) begin
            tbl_wdata = {tbl_owner, tbl_rank + RW'(1)};
        end else begin
            tbl_wdata = tbl_rdata;
        end
    end

    assign back_we    = cmd.clear_step || (cmd.reduce_step && in_range && mode_reg);
    assign back_waddr = cmd.clear_step ? clr_reg : {page_cut, offset_reg};
    assign back_wdata = cmd.clear_step ? '0 : wdata_reg;

    assign frame_we    = (cmd.access && mode_reg) || (cmd.copy_step && copy_reg != 6'd0);
    assign frame_waddr = cmd.copy_step ? {frame_reg, copy_prev[OFFSET_W-1:0]}
                                       : {frame_reg, offset_reg};
    assign frame_wdata = cmd.copy_step ? back_rdata : wdata_reg;

    lpmt_ram #(.WIDTH(TBL_W), .DEPTH(FRAME_COUNT)) u_table (
        .aclk  (aclk),
        .we    (cmd.promote_step && pend_reg),
        .waddr (pend_idx_reg),
        .wdata (tbl_wdata),
        .raddr (idx_reg[FW-1:0]),
        .rdata (tbl_rdata)
    );

    lpmt_ram #(.WIDTH(DATA_W), .DEPTH(BACK_DEPTH)) u_backing (
        .aclk  (aclk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr ({page_cut, copy_reg[OFFSET_W-1:0]}),
        .rdata (back_rdata)
    );

    lpmt_ram #(.WIDTH(DATA_W), .DEPTH(FRAME_COUNT * PAGE_BYTES)) u_frames (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr ({frame_reg, offset_reg}),
        .rdata (frame_rdata)
    );

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= s_data.mode;
            page_reg   <= s_data.virtual_address[VADDR_W-1:OFFSET_W];
            offset_reg <= s_data.virtual_address[OFFSET_W-1:0];
            wdata_reg  <= s_data.write_data;
        end else if (cmd.reduce_step && !in_range) begin
            page_reg <= page_reg - RAW_PAGE_W'(EFF_PAGES);
        end

        if ((cmd.scan_step || cmd.promote_step) && idx_reg < fill_reg) begin
            pend_idx_reg <= idx_reg[FW-1:0];
        end

        if (cmd.scan_step && pend_reg) begin
            if (tbl_owner == page_cut) begin
                hit_frame_reg <= pend_idx_reg;
                hit_rank_reg  <= tbl_rank;
            end
            if (tbl_rank == RW'(FRAME_COUNT - 1)) begin
                lru_frame_reg <= pend_idx_reg;
            end
        end

        if (cmd.decide) begin
            if (hit_reg) begin
                frame_reg    <= hit_frame_reg;
                old_rank_reg <= CW'(hit_rank_reg);
            end else if (fill_reg < CW'(FRAME_COUNT)) begin
                frame_reg    <= fill_reg[FW-1:0];
                old_rank_reg <= CW'(FRAME_COUNT);
            end else begin
                frame_reg    <= lru_frame_reg;
                old_rank_reg <= CW'(FRAME_COUNT - 1);
            end
        end

        if (cmd.copy_step && copy_reg != 6'd0 && copy_prev[OFFSET_W-1:0] == offset_reg) begin
            rdata_reg <= back_rdata;
        end

        if (cmd.finish && out_free) begin
            out_reg.read_data   <= mode_reg ? '0 : (hit_reg ? frame_rdata : rdata_reg);
            out_reg.page_fault  <= !hit_reg;
            out_reg.frame_used  <= FRAME_OUT_W'(frame_reg);
            out_reg.fault_total <= fault_total_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg         <= '0;
            idx_reg         <= '0;
            pend_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            fill_reg        <= '0;
            fault_total_reg <= '0;
            copy_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + BACK_AW'(1);
            end

            if (cmd.reduce_step && in_range) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
            end else if (cmd.scan_step || cmd.promote_step) begin
                pend_reg <= (idx_reg < fill_reg);
                if (idx_reg < fill_reg) begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end else if (cmd.decide) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end

            if (cmd.scan_step && pend_reg && tbl_owner == page_cut) begin
                hit_reg <= 1'b1;
            end

            if (cmd.decide) begin
                copy_reg <= '0;
                if (!hit_reg) begin
                    if (fill_reg < CW'(FRAME_COUNT)) begin
                        fill_reg <= fill_reg + CW'(1);
                    end
                    if (fault_total_reg != '1) begin
                        fault_total_reg <= fault_total_reg + FAULT_W'(1);
                    end
                end
            end else if (cmd.copy_step) begin
                copy_reg <= copy_reg + 6'd1;
            end

            if (cmd.finish && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// ===== design/lpmt_ctrl.sv =====
// Controller state machine: sequences the clear pass and each access.
module lpmt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lpmt_pkg::lpmt_status_t status,
    output lpmt_pkg::lpmt_cmd_t    cmd
);
    import lpmt_pkg::*;

    lpmt_state_t state_reg;
    lpmt_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.reduce_step = 1'b1;
                if (status.page_in_range) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.pass_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_PROMOTE;
            end
            ST_PROMOTE: begin
                cmd.promote_step = 1'b1;
                if (status.pass_done) begin
                    state_next = status.is_hit ? ST_ACCESS : ST_COPY;
                end
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                state_next = ST_FINISH;
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (status.copy_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== design/lru_paged_memory_translator.sv =====
// Top level of the LRU paged memory translator: controller, datapath and checks.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (mode, virtual_address, write_data)
//  m_      | out       | m_valid / m_ready  | m_data  (read_data, page_fault, frame_used,
//          |           |                    |          fault_total)
//
// After reset a clearing pass zeroes the backing store, one byte a cycle, and s_ready
// stays low until it ends. For each access the frame table RAM is walked once to search
// and once to update ranks, and a miss copies the 32-byte page one byte a cycle. An
// out-of-range page is first reduced by subtracting VIRTUAL_PAGES until it is in range.
// After each result the controller returns to idle before it takes the next transfer.
// One access is in flight at a time; a new transfer is taken while a result waits.
module lru_paged_memory_translator #(
    parameter int FRAME_COUNT   = 64,
    parameter int VIRTUAL_PAGES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lpmt_pkg::lpmt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lpmt_pkg::lpmt_out_t m_data
);
    import lpmt_pkg::*;

    lpmt_cmd_t    cmd;
    lpmt_status_t status;

    lpmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lpmt_datapath #(
        .FRAME_COUNT   (FRAME_COUNT),
        .VIRTUAL_PAGES (VIRTUAL_PAGES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.finish))
        else $error("result raised without a finish step");

    a_accept_starts_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.reduce_step)
        else $error("accepted transfer did not start address reduction");

    a_access_only_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.access |-> status.is_hit)
        else $error("hit access step on a miss");

    a_copy_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_step |-> !status.is_hit)
        else $error("page copy on a hit");
endmodule
